### rtl/core/dam_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Decimal accumulator machine package
// Shared payload types, status codes, opcodes and controller states.
// ---------------------------------------------------------------------------
package dam_pkg;

	localparam int WORD_W = 32;
	localparam int ADDR_W = 7;

	typedef struct packed {
		logic               operation;
		logic [ADDR_W-1:0]  address;
		logic signed [31:0] value;
	} dam_in_t;

	typedef struct packed {
		logic [3:0]         status;
		logic [ADDR_W-1:0]  out_address;
		logic signed [31:0] out_value;
		logic [ADDR_W-1:0]  program_counter;
		logic signed [31:0] accumulator;
	} dam_out_t;

	localparam logic [3:0] ST_OK       = 4'd0;
	localparam logic [3:0] ST_WROTE    = 4'd1;
	localparam logic [3:0] ST_HALT     = 4'd2;
	localparam logic [3:0] ST_PAST_END = 4'd3;
	localparam logic [3:0] ST_BAD_IN   = 4'd4;
	localparam logic [3:0] ST_BAD_OP   = 4'd5;
	localparam logic [3:0] ST_DIV_ZERO = 4'd6;
	localparam logic [3:0] ST_LOAD_REJ = 4'd7;
	localparam logic [3:0] ST_STOPPED  = 4'd8;

	// Opcode given to any word outside 0..4399; words 0..99 also decode to it.
	localparam logic [6:0] OP_NONE  = 7'd0;
	localparam logic [6:0] OP_READ  = 7'd10;
	localparam logic [6:0] OP_WRITE = 7'd11;
	localparam logic [6:0] OP_LOAD  = 7'd20;
	localparam logic [6:0] OP_STORE = 7'd21;
	localparam logic [6:0] OP_ADD   = 7'd30;
	localparam logic [6:0] OP_SUB   = 7'd31;
	localparam logic [6:0] OP_DIV   = 7'd32;
	localparam logic [6:0] OP_MUL   = 7'd33;
	localparam logic [6:0] OP_BR    = 7'd40;
	localparam logic [6:0] OP_BRNEG = 7'd41;
	localparam logic [6:0] OP_BRZ   = 7'd42;
	localparam logic [6:0] OP_HALT  = 7'd43;

	localparam logic signed [31:0] WORD_MAX = 32'sd9999;
	localparam logic signed [31:0] WORD_MIN = -32'sd9999;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_FETCH, S_SPLIT, S_OPER, S_EXEC,
		S_MUL, S_DIV, S_RESP
	} dam_state_t;

	// Divider handshake.
	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} dam_div_req_t;

	// Range check for program and keyboard words.
	function automatic logic in_range(input logic signed [31:0] v);
		in_range = (v <= WORD_MAX) && (v >= WORD_MIN);
	endfunction

endpackage

### rtl/core/decimal_accumulator_machine.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Decimal accumulator machine
// Program memory, fetch and execute sequencer with a bit-serial divider.
// ---------------------------------------------------------------------------
// The 100 program words live in a single-port RAM with registered read.
// After reset a clearing pass writes zero to every word, during which no item
// is taken. One item is handled at a time. The result register is loaded as
// a load, or a step that is stopped or past the end, leaves S_FETCH; as any
// other step leaves S_EXEC after fetch, split and operand read; as a multiply
// leaves S_MUL; and as a divide leaves S_DIV, where it waits for the divider.
// in_ready stays low while an item is in work and while its result waits, so
// the next is accepted at the earliest on the edge after the result transfers.
// ---------------------------------------------------------------------------
module decimal_accumulator_machine #(
	parameter int MEM_WORDS = 100
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  dam_pkg::dam_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output dam_pkg::dam_out_t out_data
);
	import dam_pkg::*;

	localparam int AW = $clog2(MEM_WORDS);

	dam_state_t state_q, state_d;
	dam_in_t    item_q;
	logic [6:0]  pc_q;
	logic [31:0] acc_q;
	logic        stop_q;
	logic [AW-1:0] idx_q;
	logic [6:0]  opc_q;
	logic [31:0] mulp_q;
	logic [AW:0] clr_q;
	dam_out_t    res_q;
	logic        res_v_q;

	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [31:0]   ram_wdata, ram_rdata;
	dam_div_req_t  dreq;
	logic          ddone;
	logic [31:0]   dquo;

	dam_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);
	dam_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .done(ddone), .quotient(dquo));

	// Only words 0..4399 can hold a defined opcode; any other word decodes as
	// an unknown opcode. In that range x / 100 equals (x * 5243) >> 19.
	logic signed [31:0] w;
	logic        dec_ok;
	logic [12:0] wlow;
	logic [25:0] qprod;
	logic [6:0]  dec_opc;
	logic [6:0]  dec_rem;
	assign w       = ram_rdata;
	assign dec_ok  = (w >= 32'sd0) && (w < 32'sd4400);
	assign wlow    = w[12:0];
	assign qprod   = {13'd0, wlow} * 26'd5243;
	assign dec_opc = qprod[25:19];
	assign dec_rem = 7'(wlow - {6'd0, dec_opc} * 13'd100);

	logic ld_ok, kb_ok, res_free, fire;
	assign ld_ok    = in_range(item_q.value) && (item_q.address < 7'(MEM_WORDS));
	assign kb_ok    = in_range(item_q.value);
	assign res_free = !res_v_q || out_ready;
	assign in_ready = (state_q == S_IDLE);

	dam_out_t   res_d;
	logic       fire_d;
	logic [6:0] pc_d;
	logic [31:0] acc_d;
	logic        stop_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			pc_q    <= '0;
			acc_q   <= '0;
			stop_q  <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			pc_q   <= pc_d;
			acc_q  <= acc_d;
			stop_q <= stop_d;
			if (fire_d) begin
				res_v_q <= 1'b1;
			end else if (out_ready) begin
				res_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= in_data;
		end
		if (state_q == S_SPLIT) begin
			if (dec_ok) begin
				opc_q <= dec_opc;
				idx_q <= (dec_rem < 7'(MEM_WORDS)) ? AW'(dec_rem) : '0;
			end else begin
				opc_q <= OP_NONE;
				idx_q <= '0;
			end
		end
		if (state_q == S_EXEC) begin
			mulp_q <= 32'(acc_q * ram_rdata);
		end
		if (fire_d) begin
			res_q <= res_d;
		end
	end
	assign fire = fire_d;

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_addr  = idx_q;
		ram_wdata = acc_q;
		dreq      = '{start: 1'b0, dividend: acc_q, divisor: ram_rdata};
		fire_d    = 1'b0;
		pc_d      = pc_q;
		acc_d     = acc_q;
		stop_d    = stop_q;
		res_d     = '{status: ST_OK, out_address: '0, out_value: '0,
			program_counter: pc_q, accumulator: acc_q};
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_q[AW-1:0];
				ram_wdata = '0;
				if (clr_q == (AW+1)'(MEM_WORDS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_FETCH;
				end
			end
			S_FETCH: begin
				ram_addr = AW'(pc_q);
				if (!item_q.operation) begin
					if (ld_ok) begin
						ram_we    = 1'b1;
						ram_addr  = AW'(item_q.address);
						ram_wdata = item_q.value;
					end else begin
						res_d.status = ST_LOAD_REJ;
					end
					state_d = S_RESP;
				end else if (stop_q) begin
					res_d.status = ST_STOPPED;
					state_d = S_RESP;
				end else if (pc_q >= 7'(MEM_WORDS)) begin
					stop_d = 1'b1;
					res_d.status = ST_PAST_END;
					res_d.program_counter = pc_q;
					state_d = S_RESP;
				end else begin
					pc_d    = pc_q + 7'd1;
					state_d = S_SPLIT;
				end
			end
			S_SPLIT: state_d = S_OPER;
			S_OPER: state_d = S_EXEC;
			S_EXEC: begin
				state_d = S_RESP;
				case (opc_q)
					OP_READ: begin
						if (kb_ok) begin
							ram_we    = 1'b1;
							ram_wdata = item_q.value;
						end else begin
							stop_d = 1'b1;
							res_d.status = ST_BAD_IN;
						end
					end
					OP_WRITE: begin
						res_d.status      = ST_WROTE;
						res_d.out_address = 7'(idx_q);
						res_d.out_value   = ram_rdata;
					end
					OP_LOAD:  acc_d = ram_rdata;
					OP_STORE: ram_we = 1'b1;
					OP_ADD:   acc_d = acc_q + ram_rdata;
					OP_SUB:   acc_d = acc_q - ram_rdata;
					OP_MUL:   state_d = S_MUL;
					OP_DIV: begin
						if (ram_rdata == 32'd0) begin
							stop_d = 1'b1;
							res_d.status = ST_DIV_ZERO;
						end else begin
							dreq.start = 1'b1;
							state_d    = S_DIV;
						end
					end
					OP_BR:    pc_d = 7'(idx_q);
					OP_BRNEG: if (acc_q[31]) pc_d = 7'(idx_q);
					OP_BRZ:   if (acc_q == 32'd0) pc_d = 7'(idx_q);
					OP_HALT: begin
						stop_d = 1'b1;
						res_d.status = ST_HALT;
					end
					default: begin
						stop_d = 1'b1;
						res_d.status = ST_BAD_OP;
					end
				endcase
				res_d.program_counter = pc_d;
				res_d.accumulator     = acc_d;
			end
			S_MUL: begin
				acc_d   = mulp_q;
				res_d.accumulator = mulp_q;
				state_d = S_RESP;
			end
			S_DIV: begin
				if (ddone) begin
					acc_d   = dquo;
					res_d.accumulator = dquo;
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (res_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		// The result of an item transfers into the output register on entry to S_RESP.
		if (state_q != S_RESP && state_d == S_RESP) begin
			fire_d = 1'b1;
		end
	end

	assign out_valid = res_v_q;
	assign out_data  = res_q;

	// Output register must never be overwritten while a result waits.
	assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> !res_v_q) else $error("result overwritten");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("result dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !in_ready) else $error("accept during clear");
	assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= 7'(MEM_WORDS)) else $error("counter out of range");
endmodule

### rtl/core/dam_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle; a write also reads the old word; read data is registered.
// ---------------------------------------------------------------------------
module dam_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 100
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

### rtl/core/dam_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Signed divider
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// ---------------------------------------------------------------------------
module dam_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dam_pkg::dam_div_req_t req,
	output logic                  done,
	output logic [31:0]           quotient
);
	import dam_pkg::*;

	logic [31:0] rem_q, quo_q, dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q, neg_q, done_q;
	logic [32:0] trial;
	logic [32:0] shifted;

	assign shifted = {rem_q, quo_q[31]};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend[31] ? (~req.dividend + 32'd1) : req.dividend;
			dvs_q <= req.divisor[31] ? (~req.divisor + 32'd1) : req.divisor;
			neg_q <= req.dividend[31] ^ req.divisor[31];
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (~quo_q + 32'd1) : quo_q;
endmodule

### test/decimal_accumulator_machine_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Decimal accumulator machine testbench
// Loads programs and runs steps through the valid/ready ports, predicts
// every result with an in-bench machine model and checks each transfer.
// ---------------------------------------------------------------------------
module decimal_accumulator_machine_test;
	import dam_pkg::*;

	class dam_scoreboard;
		logic signed [31:0] mem_words [100];
		logic [6:0]         pc;
		logic signed [31:0] acc;
		bit                 halted;
		dam_out_t           pending [$];
		int                 errors;

		function new();
			for (int i = 0; i < 100; i++) mem_words[i] = '0;
			pc = '0;
			acc = '0;
			halted = 1'b0;
			errors = 0;
		endfunction

		function bit word_ok(logic signed [31:0] v);
			return v <= 32'sd9999 && v >= -32'sd9999;
		endfunction

		// Works out the result of one accepted input item.
		function void note_input(dam_in_t it);
			dam_out_t r;
			logic signed [31:0] w, op, arg, q;
			int idx;
			r = '0;
			if (it.operation == 1'b0) begin
				if (it.address >= 100 || !word_ok(it.value))
					r.status = ST_LOAD_REJ;
				else
					mem_words[it.address] = it.value;
			end else if (halted) begin
				r.status = ST_STOPPED;
			end else if (pc >= 100) begin
				halted = 1'b1;
				r.status = ST_PAST_END;
			end else begin
				w = mem_words[pc];
				pc = pc + 7'd1;
				op = w / 100;
				arg = w % 100;
				idx = (arg < 0) ? 0 : arg;
				r.status = ST_OK;
				if (op == OP_READ) begin
					if (!word_ok(it.value)) begin
						halted = 1'b1;
						r.status = ST_BAD_IN;
					end else
						mem_words[idx] = it.value;
				end else if (op == OP_WRITE) begin
					r.status = ST_WROTE;
					r.out_address = 7'(idx);
					r.out_value = mem_words[idx];
				end else if (op == OP_LOAD) acc = mem_words[idx];
				else if (op == OP_STORE) mem_words[idx] = acc;
				else if (op == OP_ADD) acc = acc + mem_words[idx];
				else if (op == OP_SUB) acc = acc - mem_words[idx];
				else if (op == OP_DIV) begin
					if (mem_words[idx] == 0) begin
						halted = 1'b1;
						r.status = ST_DIV_ZERO;
					end else if (acc == 32'sh80000000 && mem_words[idx] == -1)
						acc = acc;
					else begin
						q = acc / mem_words[idx];
						acc = q;
					end
				end else if (op == OP_MUL) acc = acc * mem_words[idx];
				else if (op == OP_BR) pc = 7'(idx);
				else if (op == OP_BRNEG) begin
					if (acc < 0) pc = 7'(idx);
				end else if (op == OP_BRZ) begin
					if (acc == 0) pc = 7'(idx);
				end else if (op == OP_HALT) begin
					halted = 1'b1;
					r.status = ST_HALT;
				end else begin
					halted = 1'b1;
					r.status = ST_BAD_OP;
				end
			end
			r.program_counter = pc;
			r.accumulator = acc;
			pending.push_back(r);
		endfunction

		function void check_result(dam_out_t got);
			dam_out_t exp_r;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $realtime, got);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (got.status !== exp_r.status) begin
				$display("%0t: status expected %0d actual %0d", $realtime, exp_r.status,
					got.status);
				errors++;
			end
			if (got.out_address !== exp_r.out_address) begin
				$display("%0t: out_address expected %0d actual %0d", $realtime,
					exp_r.out_address, got.out_address);
				errors++;
			end
			if (got.out_value !== exp_r.out_value) begin
				$display("%0t: out_value expected %0d actual %0d", $realtime,
					exp_r.out_value, got.out_value);
				errors++;
			end
			if (got.program_counter !== exp_r.program_counter) begin
				$display("%0t: program_counter expected %0d actual %0d", $realtime,
					exp_r.program_counter, got.program_counter);
				errors++;
			end
			if (got.accumulator !== exp_r.accumulator) begin
				$display("%0t: accumulator expected %0d actual %0d", $realtime,
					exp_r.accumulator, got.accumulator);
				errors++;
			end
		endfunction
	endclass

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	dam_in_t  in_data;
	logic     out_valid;
	logic     out_ready;
	dam_out_t out_data;

	dam_scoreboard machine_model;
	int        gap_left;
	int        hold_cycles;
	int        rx_cycles;
	bit        stimulus_done;

	decimal_accumulator_machine u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("tb: failure");
		$finish;
	end

	// Sends one item, with a random gap before it now and then.
	task automatic send_item(input logic operation, input logic [6:0] address,
			input logic signed [31:0] value);
		dam_in_t it;
		if (gap_left == 0 && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		if (gap_left > 0) gap_left--;
		else if ($urandom_range(0, 9) == 0) gap_left = $urandom_range(5, 40);
		it.operation = operation;
		it.address = address;
		it.value = value;
		in_data <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		machine_model.note_input(it);
	endtask

	task automatic load_word(input int addr, input int w);
		send_item(1'b0, addr[6:0], w);
	endtask

	task automatic step(input logic signed [31:0] key);
		send_item(1'b1, 7'($urandom_range(0, 127)), key);
	endtask

	function automatic int enc(input logic [6:0] op, input int addr);
		return op * 100 + addr;
	endfunction

	function automatic logic signed [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 19998) - 9999;
			1: return $urandom;
			2: return 32'sd9999;
			3: return -32'sd9999;
			default: return $urandom_range(0, 200) - 100;
		endcase
	endfunction

	// A random program with mostly valid opcodes and small operands.
	task automatic load_random_program(input int len);
		logic [6:0] ops [12];
		int w;
		ops = '{OP_READ, OP_WRITE, OP_LOAD, OP_STORE, OP_ADD, OP_SUB, OP_DIV,
			OP_MUL, OP_BR, OP_BRNEG, OP_BRZ, OP_HALT};
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 19) == 0) w = rand_word();
			else if ($urandom_range(0, 3) == 0) w = rand_word() % 10000;
			else w = enc(ops[$urandom_range(0, 11)], $urandom_range(0, 99));
			load_word(i, w);
		end
		for (int i = 0; i < 6; i++) load_word($urandom_range(0, 99), rand_word() % 10000);
	endtask

	// Runs n steps with random keys. A load-only restart: pc and acc are not
	// reset, so programs branch to 0 only by chance.
	task automatic run_steps(input int n);
		for (int i = 0; i < n; i++) step(rand_word());
	endtask

	always @(posedge clk) begin
		if (out_valid && out_ready) machine_model.check_result(out_data);
	end

	// Receiver stall pattern, with a long hold-off at a fixed cycle count and more at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_cycles <= 0;
			rx_cycles <= 0;
		end else begin
			rx_cycles <= rx_cycles + 1;
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				hold_cycles <= hold_cycles - 1;
			end else if (rx_cycles == 2000) begin
				out_ready <= 1'b0;
				hold_cycles <= 300;
			end else if (stimulus_done) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(0, 3) != 0) || ($realtime < 3000);
				if ($urandom_range(0, 2999) == 0) hold_cycles <= 300;
			end
		end
	end

	initial begin
		int waited;
		machine_model = new();
		gap_left = 0;
		stimulus_done = 0;
		arst_n = 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		repeat (12) @(posedge clk);
		arst_n = 1'b1;

		// Directed: every opcode but HALT, range extremes and stop cases.
		load_word(0, enc(OP_READ, 50));
		load_word(1, enc(OP_LOAD, 50));
		load_word(2, enc(OP_MUL, 50));
		load_word(3, enc(OP_ADD, 51));
		load_word(4, enc(OP_SUB, 52));
		load_word(5, enc(OP_DIV, 52));
		load_word(6, enc(OP_STORE, 53));
		load_word(7, enc(OP_WRITE, 53));
		load_word(8, enc(OP_BRNEG, 10));
		load_word(9, enc(OP_HALT, 0));
		load_word(10, enc(OP_BRZ, 12));
		load_word(11, enc(OP_BR, 13));
		load_word(13, -9999);
		load_word(51, 9999);
		load_word(52, -3);
		load_word(127, 5);
		load_word(60, 10000);
		load_word(60, -10000);
		load_word(61, 32'sh80000000);
		step(-9999);
		for (int i = 0; i < 14; i++) step(32'sh7fffffff);
		step(0);

		// Random programs; loads do not restart a run, and once stopped the
		// machine only answers stopped until reset.
		for (int p = 0; p < 28; p++) begin
			load_random_program($urandom_range(4, 14));
			run_steps($urandom_range(2, 10));
		end

		// Long straight-line program of adds, with more steps than memory words.
		for (int i = 0; i < 100; i++) load_word(i, enc(OP_ADD, 99));
		run_steps(102);

		in_valid <= 1'b0;
		stimulus_done = 1;
		waited = 0;
		while (machine_model.pending.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (60) @(posedge clk);
		if (machine_model.errors == 0 && machine_model.pending.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

### decimal_accumulator_machine.f
rtl/core/dam_pkg.sv
rtl/core/dam_ram.sv
rtl/core/dam_div.sv
rtl/core/decimal_accumulator_machine.sv
test/decimal_accumulator_machine_test.sv
